>>> rtl/bhs_pkg.sv
// Shared constants, opcodes and control structs for the Bresenham step interpolator.
package bhs_pkg;

  localparam int AXES       = 4;
  localparam int AXIS_W     = 2;
  localparam int MAX_AXES   = 8;
  localparam int STEPS_W    = 32;
  localparam int CNT_W      = 31;
  localparam int ERR_W      = 32;
  localparam int PERIOD_W   = 20;
  localparam int MIN_PERIOD = 50;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_ABORT = 2'd3
  } op_t;

  // Broadcast from the sequencer to every axis unit.
  typedef struct packed {
    logic             start;
    logic             step;
    logic [CNT_W-1:0] lead;
  } axis_ctl_t;

  // Sequencer status toward the top level.
  typedef struct packed {
    logic running;
    logic step;
    logic busy;
    logic done;
  } seq_stat_t;

endpackage

>>> rtl/bhs_axis.sv
// One axis: stored count, direction, remaining steps and Bresenham error term.
module bhs_axis (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load_en,
  input  logic [bhs_pkg::STEPS_W-1:0] load_steps,
  input  bhs_pkg::axis_ctl_t         ctl,
  output logic [bhs_pkg::CNT_W-1:0]  total,
  output logic                       neg_nxt,
  output logic                       pulse
);

  logic [bhs_pkg::CNT_W-1:0]   total_r, total_nxt;
  logic [bhs_pkg::CNT_W-1:0]   remain_r, remain_nxt;
  logic                        neg_r;
  logic [bhs_pkg::ERR_W-1:0]   err_r, err_nxt;
  logic [bhs_pkg::STEPS_W-1:0] mag_full;
  logic [bhs_pkg::CNT_W-1:0]   mag;
  logic [bhs_pkg::ERR_W:0]     sum;
  logic [bhs_pkg::ERR_W+1:0]   diff;
  logic                        hit;

  always_comb begin
    mag_full = load_steps[bhs_pkg::STEPS_W-1] ? (~load_steps + 1'b1) : load_steps;
    // Most negative count saturates to the largest magnitude
    mag = mag_full[bhs_pkg::STEPS_W-1] ? {bhs_pkg::CNT_W{1'b1}}
                                         : mag_full[bhs_pkg::CNT_W-1:0];
    sum  = {1'b0, err_r} + {2'b00, total_r};
    diff = {1'b0, sum} - {3'b000, ctl.lead};
    hit  = (remain_r != '0) && !diff[bhs_pkg::ERR_W+1];

    total_nxt  = total_r;
    neg_nxt    = neg_r;
    remain_nxt = remain_r;
    err_nxt    = err_r;
    if (load_en) begin
      total_nxt = mag;
      neg_nxt   = load_steps[bhs_pkg::STEPS_W-1];
    end
    if (ctl.start) begin
      err_nxt    = {2'b00, ctl.lead[bhs_pkg::CNT_W-1:1]};
      remain_nxt = total_r;
    end else if (ctl.step && (remain_r != '0)) begin
      if (hit) begin
        err_nxt    = diff[bhs_pkg::ERR_W-1:0];
        remain_nxt = remain_r - 1'b1;
      end else begin
        err_nxt = sum[bhs_pkg::ERR_W-1:0];
      end
    end
    pulse = ctl.step && hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      remain_r <= '0;
      neg_r    <= 1'b0;
      err_r    <= '0;
    end else begin
      total_r  <= total_nxt;
      remain_r <= remain_nxt;
      neg_r    <= neg_nxt;
      err_r    <= err_nxt;
    end
  end

  assign total = total_r;

endmodule

>>> rtl/bhs_seq.sv
// Move sequencer: lead search, step period countdown and lead progress.
module bhs_seq (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   fire,
  input  bhs_pkg::op_t                           op,
  input  logic [bhs_pkg::AXES-1:0][bhs_pkg::CNT_W-1:0] totals,
  input  logic [bhs_pkg::PERIOD_W-1:0]           period,
  output bhs_pkg::axis_ctl_t                     ctl,
  output bhs_pkg::seq_stat_t                     stat
);

  logic                           running_r, running_nxt;
  logic [bhs_pkg::CNT_W-1:0]      lead_r, lead_nxt;
  logic [bhs_pkg::CNT_W-1:0]      progress_r, progress_nxt;
  logic [bhs_pkg::PERIOD_W-1:0]   countdown_r, countdown_nxt;
  logic [bhs_pkg::PERIOD_W-1:0]   eff_period;
  logic [bhs_pkg::CNT_W-1:0]      progress_inc;
  logic [bhs_pkg::MAX_AXES-1:0][bhs_pkg::CNT_W-1:0]   lvl0;
  logic [bhs_pkg::MAX_AXES/2-1:0][bhs_pkg::CNT_W-1:0] lvl1;
  logic [bhs_pkg::MAX_AXES/4-1:0][bhs_pkg::CNT_W-1:0] lvl2;
  logic [bhs_pkg::CNT_W-1:0]      max_total;
  logic                           go, stop, step, done;

  // Pairwise max tree over the stored totals
  always_comb begin
    lvl0 = '0;
    for (int i = 0; i < bhs_pkg::AXES; i++) begin
      lvl0[i] = totals[i];
    end
    for (int i = 0; i < bhs_pkg::MAX_AXES / 2; i++) begin
      lvl1[i] = (lvl0[2*i] > lvl0[2*i+1]) ? lvl0[2*i] : lvl0[2*i+1];
    end
    for (int i = 0; i < bhs_pkg::MAX_AXES / 4; i++) begin
      lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
    end
    max_total = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
  end

  always_comb begin
    eff_period   = (period < bhs_pkg::PERIOD_W'(bhs_pkg::MIN_PERIOD))
                 ? bhs_pkg::PERIOD_W'(bhs_pkg::MIN_PERIOD) : period;
    progress_inc = progress_r + 1'b1;
    go   = fire && (op == bhs_pkg::OP_START) && (max_total != '0);
    stop = fire && ((op == bhs_pkg::OP_ABORT) ||
                    ((op == bhs_pkg::OP_START) && (max_total == '0)));
    step = fire && (op == bhs_pkg::OP_TICK) && running_r && (countdown_r == '0);
    done = step && (progress_inc == lead_r);

    running_nxt   = running_r;
    lead_nxt      = lead_r;
    progress_nxt  = progress_r;
    countdown_nxt = countdown_r;
    if (go) begin
      running_nxt   = 1'b1;
      lead_nxt      = max_total;
      progress_nxt  = '0;
      countdown_nxt = '0;
    end else if (stop) begin
      running_nxt = 1'b0;
    end else if (fire && (op == bhs_pkg::OP_TICK) && running_r) begin
      if (countdown_r != '0) begin
        countdown_nxt = countdown_r - 1'b1;
      end else begin
        progress_nxt = progress_inc;
        if (done) begin
          running_nxt = 1'b0;
        end else begin
          countdown_nxt = eff_period - 1'b1;
        end
      end
    end

    ctl.start    = go;
    ctl.step     = step;
    ctl.lead     = go ? max_total : lead_r;
    stat.running = running_r;
    stat.step    = step;
    stat.busy    = running_nxt;
    stat.done    = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      lead_r      <= '0;
      progress_r  <= '0;
      countdown_r <= '0;
    end else begin
      running_r   <= running_nxt;
      lead_r      <= lead_nxt;
      progress_r  <= progress_nxt;
      countdown_r <= countdown_nxt;
    end
  end

endmodule

>>> rtl/multi_axis_bresenham_stepper.sv
// All axes update an item in parallel between the input register and the result register.
// Throughput: one item per cycle while the result register is empty or taken.
// Input register and result register both advance when the result register is empty or taken.
// Reset (rst_n low, synchronous): move idle, all axis counts and errors zero, step_period 1000.
// Registers and counts are ready in the cycle after reset is released; no clearing pass.
module multi_axis_bresenham_stepper (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bhs_pkg::IN_TDATA_W-1:0]     in_tdata,   // axis[1:0], steps[33:2], zero pad
  input  logic [1:0]                         in_tuser,   // op[1:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bhs_pkg::OUT_TDATA_W-1:0]    out_tdata,  // step_mask[3:0], dir_mask[7:4],
                                                         // busy_res[8], zero pad
  output logic                               out_tlast,  // done_res
  input  logic                               cfg_we,
  input  logic [bhs_pkg::PERIOD_W-1:0]       cfg_wdata   // step_period
);

  logic                                 in_valid_r;
  bhs_pkg::op_t                         op_r;
  logic [bhs_pkg::AXIS_W-1:0]           axis_r;
  logic [bhs_pkg::STEPS_W-1:0]          steps_r;
  logic [bhs_pkg::PERIOD_W-1:0]         period_r;
  logic                                 out_valid_r;
  logic [bhs_pkg::AXES-1:0]             step_mask_r, dir_mask_r;
  logic                                 busy_r, done_r;
  logic                                 fire;
  bhs_pkg::axis_ctl_t                   ctl;
  bhs_pkg::seq_stat_t                   stat;
  logic [bhs_pkg::AXES-1:0][bhs_pkg::CNT_W-1:0] totals;
  logic [bhs_pkg::AXES-1:0]             pulses, dir_nxt, load_en;

  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r    <= bhs_pkg::op_t'(in_tuser);
      axis_r  <= in_tdata[bhs_pkg::AXIS_W-1:0];
      steps_r <= in_tdata[bhs_pkg::AXIS_W +: bhs_pkg::STEPS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= bhs_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      period_r <= cfg_wdata;
    end
  end

  bhs_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .op     (op_r),
    .totals (totals),
    .period (period_r),
    .ctl    (ctl),
    .stat   (stat)
  );

  for (genvar g = 0; g < bhs_pkg::AXES; g++) begin : g_axis
    // Drop loads while a move runs so the move keeps its counts
    assign load_en[g] = fire && (op_r == bhs_pkg::OP_LOAD) && !stat.running &&
                        (axis_r == bhs_pkg::AXIS_W'(g));

    bhs_axis u_axis (
      .clk        (clk),
      .rst_n      (rst_n),
      .load_en    (load_en[g]),
      .load_steps (steps_r),
      .ctl        (ctl),
      .total      (totals[g]),
      .neg_nxt    (dir_nxt[g]),
      .pulse      (pulses[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      step_mask_r <= pulses;
      dir_mask_r  <= dir_nxt;
      busy_r      <= stat.busy;
      done_r      <= stat.done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = bhs_pkg::OUT_TDATA_W'({busy_r, dir_mask_r, step_mask_r});
  assign out_tlast  = done_r;

  // Pulses only come from a lead step
  a_pulse_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pulses != '0) |-> stat.step)
    else $error("axis pulse without lead step");

  // Completion ends the move in the same transfer
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> !stat.busy)
    else $error("move done but still busy");

  // A lead step needs a running move and a tick
  a_step_running: assert property (@(posedge clk) disable iff (!rst_n)
    stat.step |-> (stat.running && fire && (op_r == bhs_pkg::OP_TICK)))
    else $error("lead step outside a running move");

  // A completed move leaves the sequencer idle
  a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |=> !stat.running)
    else $error("sequencer running after completion");

endmodule
